>>> src/dtq_pkg.sv
package dtq_pkg;

    localparam int TIME_W            = 48;
    localparam int DELAY_W           = 32;
    localparam int TAG_W             = 16;
    localparam int CNT_W             = 3;
    localparam int KEY_FIELDS        = 4;
    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int MAX_RECEIVERS_DEF = 4;

    localparam int S_TDATA_W = 200;
    localparam int M_TDATA_W = 40;
    localparam int MODE_W    = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NEW    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HANDLE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_KEY    = 2'd3;

    localparam logic [TAG_W-1:0] HANDLE_FIRST = 16'd1;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_INSERT,
        OP_HANDLE,
        OP_KEY
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] deadline;
        logic [TAG_W-1:0]  message;
        logic [TAG_W-1:0]  new_handle;
        logic [CNT_W-1:0]  count;
        logic [TAG_W-1:0]  match_handle;
        logic [TAG_W-1:0]  key;
    } cmd_t;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [TAG_W-1:0]  message;
        logic [TAG_W-1:0]  handle;
        logic [CNT_W-1:0]  count;
    } entry_t;

    typedef struct packed {
        logic keep;
        logic gone;
    } link_t;

    typedef struct packed {
        logic [4:0]       pad;
        logic             queue_full;
        logic             removed;
        logic [TAG_W-1:0] new_handle;
        logic [TAG_W-1:0] fired_message;
        logic             fired;
    } result_t;

endpackage

>>> src/dtq_slot.sv
module dtq_slot #(
    parameter int MAX_RECEIVERS = dtq_pkg::MAX_RECEIVERS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  dtq_pkg::cmd_t                          cmd,
    input  logic [MAX_RECEIVERS-1:0][dtq_pkg::TAG_W-1:0] new_rcv,
    input  logic                                   left_valid,
    input  dtq_pkg::entry_t                        left_entry,
    input  logic [MAX_RECEIVERS-1:0][dtq_pkg::TAG_W-1:0] left_rcv,
    input  logic                                   right_valid,
    input  dtq_pkg::entry_t                        right_entry,
    input  logic [MAX_RECEIVERS-1:0][dtq_pkg::TAG_W-1:0] right_rcv,
    input  dtq_pkg::link_t                         link_in,
    output dtq_pkg::link_t                         link_out,
    output logic                                   valid,
    output dtq_pkg::entry_t                        entry,
    output logic [MAX_RECEIVERS-1:0][dtq_pkg::TAG_W-1:0] rcv
);
    import dtq_pkg::*;

    logic                               valid_reg;
    logic                               valid_next;
    entry_t                             entry_reg;
    entry_t                             entry_next;
    logic [MAX_RECEIVERS-1:0][TAG_W-1:0] rcv_reg;
    logic [MAX_RECEIVERS-1:0][TAG_W-1:0] rcv_next;
    logic                               keep;
    logic                               hit;
    logic                               key_hit;

    assign keep = valid_reg && (entry_reg.deadline <= cmd.deadline);

    always_comb
    begin
        key_hit = 1'b0;
        for (int j = 0; j < MAX_RECEIVERS; j++)
        begin
            if ((j < int'(entry_reg.count)) && (rcv_reg[j] == cmd.key))
            begin
                key_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        case (cmd.op)
            OP_TICK:   hit = valid_reg && (cmd.now >= entry_reg.deadline);
            OP_HANDLE: hit = valid_reg && (entry_reg.handle == cmd.match_handle);
            OP_KEY:    hit = valid_reg && key_hit;
            default:   hit = 1'b0;
        endcase
    end

    assign link_out.keep = keep;
    assign link_out.gone = link_in.gone | hit;

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        rcv_next   = rcv_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                if (!keep)
                begin
                    if (link_in.keep)
                    begin
                        valid_next          = 1'b1;
                        entry_next.deadline = cmd.deadline;
                        entry_next.message  = cmd.message;
                        entry_next.handle   = cmd.new_handle;
                        entry_next.count    = cmd.count;
                        rcv_next            = new_rcv;
                    end
                    else
                    begin
                        valid_next = left_valid;
                        entry_next = left_entry;
                        rcv_next   = left_rcv;
                    end
                end
            end
            OP_TICK, OP_HANDLE, OP_KEY:
            begin
                if (link_out.gone)
                begin
                    valid_next = right_valid;
                    entry_next = right_entry;
                    rcv_next   = right_rcv;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        rcv_reg   <= rcv_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;
    assign rcv   = rcv_reg;

endmodule

>>> src/deadline_timer_queue.sv
// Tick, new timer and cancel by handle give their result word in the cycle after acceptance.
// Cancel by key drops one of its k matching slots per cycle, then gives its word when none is left.
// Throughput: one word per cycle for tick, new timer and cancel by handle unless the output stalls;
// all slots update in the same cycle; cancel by key holds the input until its sweep ends.
// Reset: asynchronous, active low; clears all slot valid bits and the output valid flag, and
// sets the next handle to one.
module deadline_timer_queue #(
    parameter int QUEUE_DEPTH   = dtq_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_RECEIVERS = dtq_pkg::MAX_RECEIVERS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // now_time, delay, message_id, receiver_count, receiver_a, receiver_b, receiver_c,
    // receiver_d, cancel_handle, cancel_key, zero fill
    input  logic [dtq_pkg::S_TDATA_W-1:0]  s_tdata,
    // mode
    input  logic [dtq_pkg::MODE_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // fired, fired_message, new_handle, removed, queue_full, zero fill
    output logic [dtq_pkg::M_TDATA_W-1:0]  m_tdata
);
    import dtq_pkg::*;

    localparam int RCV_LIM = (MAX_RECEIVERS < KEY_FIELDS) ? MAX_RECEIVERS : KEY_FIELDS;

    logic [TIME_W-1:0]                  in_now;
    logic [DELAY_W-1:0]                 in_delay;
    logic [TAG_W-1:0]                   in_message;
    logic [CNT_W-1:0]                   in_count;
    logic [KEY_FIELDS-1:0][TAG_W-1:0]   in_keys;
    logic [TAG_W-1:0]                   in_cancel_handle;
    logic [TAG_W-1:0]                   in_cancel_key;
    logic [TIME_W:0]                    sum;
    logic [CNT_W-1:0]                   cnt_clamped;
    logic [MAX_RECEIVERS-1:0][TAG_W-1:0] new_rcv;

    state_t           state_reg;
    state_t           state_next;
    logic [TAG_W-1:0] key_reg;
    logic [TAG_W-1:0] key_next;
    logic             removed_reg;
    logic             removed_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_reg;
    result_t          out_next;
    logic [TAG_W-1:0] handle_reg;
    logic [TAG_W-1:0] handle_next;

    logic   accept;
    logic   out_free;
    logic   full;
    logic   any_hit;
    cmd_t   cmd;

    logic                                valid_q [QUEUE_DEPTH];
    entry_t                              entry_q [QUEUE_DEPTH];
    logic [MAX_RECEIVERS-1:0][TAG_W-1:0] rcv_q   [QUEUE_DEPTH];
    link_t                               link_q  [QUEUE_DEPTH+1];

    assign in_now           = s_tdata[47:0];
    assign in_delay         = s_tdata[79:48];
    assign in_message       = s_tdata[95:80];
    assign in_count         = s_tdata[98:96];
    assign in_keys[0]       = s_tdata[114:99];
    assign in_keys[1]       = s_tdata[130:115];
    assign in_keys[2]       = s_tdata[146:131];
    assign in_keys[3]       = s_tdata[162:147];
    assign in_cancel_handle = s_tdata[178:163];
    assign in_cancel_key    = s_tdata[194:179];

    assign sum = {1'b0, in_now} + {{(TIME_W + 1 - DELAY_W){1'b0}}, in_delay};
    assign cnt_clamped = (int'(in_count) > RCV_LIM) ? CNT_W'(RCV_LIM) : in_count;

    always_comb
    begin
        for (int j = 0; j < MAX_RECEIVERS; j++)
        begin
            new_rcv[j] = '0;
            if ((j < KEY_FIELDS) && (j < int'(cnt_clamped)))
            begin
                new_rcv[j] = in_keys[j[1:0]];
            end
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign full     = valid_q[QUEUE_DEPTH-1];
    assign any_hit  = link_q[QUEUE_DEPTH].gone;

    always_comb
    begin
        cmd.op           = OP_NONE;
        cmd.now          = in_now;
        cmd.deadline     = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        cmd.message      = in_message;
        cmd.new_handle   = handle_reg;
        cmd.count        = cnt_clamped;
        cmd.match_handle = in_cancel_handle;
        cmd.key          = in_cancel_key;
        if (state_reg == ST_SWEEP)
        begin
            cmd.op  = OP_KEY;
            cmd.key = key_reg;
        end
        else if (accept)
        begin
            case (s_tuser)
                MODE_TICK:   cmd.op = OP_TICK;
                MODE_NEW:    cmd.op = full ? OP_NONE : OP_INSERT;
                MODE_HANDLE: cmd.op = OP_HANDLE;
                MODE_KEY:    cmd.op = OP_KEY;
                default:     cmd.op = OP_NONE;
            endcase
        end
    end

    assign link_q[0].keep = 1'b1;
    assign link_q[0].gone = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_slot
        logic                                lv;
        entry_t                              le;
        logic [MAX_RECEIVERS-1:0][TAG_W-1:0] lr;
        logic                                rv;
        entry_t                              re;
        logic [MAX_RECEIVERS-1:0][TAG_W-1:0] rr;

        if (i == 0)
        begin : g_first
            assign lv = 1'b0;
            assign le = '0;
            assign lr = '0;
        end
        else
        begin : g_mid
            assign lv = valid_q[i-1];
            assign le = entry_q[i-1];
            assign lr = rcv_q[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign rv = 1'b0;
            assign re = '0;
            assign rr = '0;
        end
        else
        begin : g_inner
            assign rv = valid_q[i+1];
            assign re = entry_q[i+1];
            assign rr = rcv_q[i+1];
        end

        dtq_slot #(
            .MAX_RECEIVERS (MAX_RECEIVERS)
        ) u_slot (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .new_rcv     (new_rcv),
            .left_valid  (lv),
            .left_entry  (le),
            .left_rcv    (lr),
            .right_valid (rv),
            .right_entry (re),
            .right_rcv   (rr),
            .link_in     (link_q[i]),
            .link_out    (link_q[i+1]),
            .valid       (valid_q[i]),
            .entry       (entry_q[i]),
            .rcv         (rcv_q[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        removed_next   = removed_reg;
        handle_next    = handle_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_next = '0;
                    case (s_tuser)
                        MODE_TICK:
                        begin
                            out_valid_next         = 1'b1;
                            out_next.fired         = any_hit;
                            out_next.fired_message = any_hit ? entry_q[0].message : '0;
                        end
                        MODE_NEW:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                            begin
                                out_next.queue_full = 1'b1;
                            end
                            else
                            begin
                                out_next.new_handle = handle_reg;
                                handle_next = (handle_reg == {TAG_W{1'b1}}) ? HANDLE_FIRST
                                                                            : handle_reg + 1'b1;
                            end
                        end
                        MODE_HANDLE:
                        begin
                            out_valid_next   = 1'b1;
                            out_next.removed = any_hit;
                        end
                        MODE_KEY:
                        begin
                            state_next   = ST_SWEEP;
                            key_next     = in_cancel_key;
                            removed_next = any_hit;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (any_hit)
                begin
                    removed_next = 1'b1;
                end
                else if (out_free)
                begin
                    state_next       = ST_IDLE;
                    out_valid_next   = 1'b1;
                    out_next         = '0;
                    out_next.removed = removed_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            handle_reg    <= HANDLE_FIRST;
            removed_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            handle_reg    <= handle_next;
            removed_reg   <= removed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

>>> src/dtq_checker.sv
module dtq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [dtq_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [dtq_pkg::MODE_W-1:0]    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dtq_pkg::M_TDATA_W-1:0] m_tdata
);
    import dtq_pkg::*;

    result_t res;

    assign res = m_tdata;

    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $countones({res.fired, res.removed, res.queue_full,
                                 res.new_handle != '0}) <= 1)
        else $error("more than one outcome in a result word");

    a_no_stale_message: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !res.fired) |-> (res.fired_message == '0))
        else $error("message tag without a fired timer");

    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser != MODE_KEY)) |=> m_tvalid)
        else $error("result word missing one cycle after acceptance");

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");

    a_unused_in: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == MODE_KEY)) |=> !s_tready)
        else $error("input taken during key sweep");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (.*);
